// File: design/rdg_pkg.sv
// Shared types, codes and constants for the radar detection gate and scan counter.
package rdg_pkg;

   // Fixed field widths
   localparam int DATA_W     = 32;
   localparam int ID_W       = 8;
   localparam int OP_W       = 2;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 3;

   // Default scan capacities in packets
   localparam int NEAR_PACKETS_DEF = 18;
   localparam int FAR_PACKETS_DEF  = 12;

   // Event id ranges
   localparam logic [ID_W-1:0] NEAR_ID_LO = 8'd3;
   localparam logic [ID_W-1:0] NEAR_ID_HI = 8'd5;
   localparam logic [ID_W-1:0] FAR_ID_LO  = 8'd1;
   localparam logic [ID_W-1:0] FAR_ID_HI  = 8'd2;

   // Scan type select values
   localparam logic MODE_NEAR = 1'b0;
   localparam logic MODE_FAR  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_SEL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNR_MIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AZIMUTH_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL_VEL_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEVATION_MIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_SEC_MIN = 3'd6;

   // Threshold reset values
   localparam logic signed [DATA_W-1:0] THR_ZERO = '0;
   localparam logic signed [DATA_W-1:0] THR_MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_HEADER = 2'd0,
      OP_DETECT = 2'd1,
      OP_END    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_APPEND  = 2'd1,
      ST_RESTART = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // Six detection values, also used for the six thresholds
   typedef struct packed {
      logic signed [DATA_W-1:0] snr;
      logic signed [DATA_W-1:0] azimuth;
      logic signed [DATA_W-1:0] range_value;
      logic signed [DATA_W-1:0] radial_velocity;
      logic signed [DATA_W-1:0] elevation;
      logic signed [DATA_W-1:0] cross_section;
   } sample_type;

   // One result beat
   typedef struct packed {
      logic              keep_detection;
      status_type        packet_status;
      logic              scan_complete;
      logic [DATA_W-1:0] scan_time;
   } rsp_type;

endpackage

// File: design/rdg_gate.sv
// Threshold gate: a detection passes when all six values reach their minimums.
module rdg_gate
   import rdg_pkg::*;
(
   input  sample_type sample,
   input  sample_type thr,
   output logic       pass
);

   // Signed compare, value >= threshold, on every field
   assign pass = ($signed(sample.snr)             >= $signed(thr.snr))
              && ($signed(sample.azimuth)         >= $signed(thr.azimuth))
              && ($signed(sample.range_value)     >= $signed(thr.range_value))
              && ($signed(sample.radial_velocity) >= $signed(thr.radial_velocity))
              && ($signed(sample.elevation)       >= $signed(thr.elevation))
              && ($signed(sample.cross_section)   >= $signed(thr.cross_section));

endmodule

// File: design/rdg_scan.sv
// Packet header tracking and per-type scan counters; builds the result of one item.
module rdg_scan
   import rdg_pkg::*;
#(
   parameter int NEAR_PACKETS = NEAR_PACKETS_DEF,
   parameter int FAR_PACKETS  = FAR_PACKETS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [OP_W-1:0]   op,
   input  logic [ID_W-1:0]   packet_id,
   input  logic [DATA_W-1:0] packet_time,
   input  logic              mode_sel,
   input  logic              det_pass,
   output rsp_type           result
);

   localparam logic [CNT_W-1:0] NEAR_CAP = CNT_W'(NEAR_PACKETS);
   localparam logic [CNT_W-1:0] FAR_CAP  = CNT_W'(FAR_PACKETS);

   // Scan state, index 0 near, 1 far
   logic [DATA_W-1:0] start_ff [2];
   logic [DATA_W-1:0] start_in [2];
   logic [CNT_W-1:0]  count_ff [2];
   logic [CNT_W-1:0]  count_in [2];

   // Current packet header
   logic [DATA_W-1:0] hdr_time_ff, hdr_time_in;
   logic              hdr_far_ff, hdr_far_in;
   logic              hdr_acc_ff, hdr_acc_in;

   logic              is_near, is_far;
   logic              t;
   logic [CNT_W-1:0]  cap;
   logic [CNT_W-1:0]  cnt;
   logic [CNT_W-1:0]  cnt_inc;
   logic [DATA_W-1:0] eff_start;

   always_comb begin
      is_near   = packet_id inside {[NEAR_ID_LO:NEAR_ID_HI]};
      is_far    = packet_id inside {[FAR_ID_LO:FAR_ID_HI]};
      t         = hdr_far_ff;
      cap       = t ? FAR_CAP : NEAR_CAP;
      cnt       = count_ff[t];
      cnt_inc   = cnt + CNT_W'(1);
      // an unset start time takes the header time
      eff_start = (start_ff[t] == '0) ? hdr_time_ff : start_ff[t];
   end

   // Next state and result
   always_comb begin
      start_in[0] = start_ff[0];
      start_in[1] = start_ff[1];
      count_in[0] = count_ff[0];
      count_in[1] = count_ff[1];
      hdr_time_in = hdr_time_ff;
      hdr_far_in  = hdr_far_ff;
      hdr_acc_in  = hdr_acc_ff;
      result      = '0;
      case (op)
         OP_HEADER: begin
            hdr_time_in = packet_time;
            hdr_far_in  = is_far;
            hdr_acc_in  = (is_near && mode_sel == MODE_NEAR)
                       || (is_far && mode_sel == MODE_FAR);
         end
         OP_DETECT: begin
            result.keep_detection = hdr_acc_ff && det_pass;
         end
         OP_END: begin
            if (!hdr_acc_ff) begin
               result.packet_status = ST_IGNORED;
            end else begin
               hdr_acc_in = 1'b0;
               if (cnt != cap && hdr_time_ff == eff_start) begin
                  // same scan: append
                  result.packet_status = ST_APPEND;
                  result.scan_time     = eff_start;
                  if (cnt_inc == cap) begin
                     result.scan_complete = 1'b1;
                     count_in[t] = '0;
                     start_in[t] = '0;
                  end else begin
                     count_in[t] = cnt_inc;
                     start_in[t] = eff_start;
                  end
               end else begin
                  // new timestamp or full count: restart with this packet
                  result.packet_status = ST_RESTART;
                  result.scan_time     = hdr_time_ff;
                  count_in[t] = CNT_W'(1);
                  start_in[t] = hdr_time_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= '0;
         start_ff[1] <= '0;
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         hdr_time_ff <= '0;
         hdr_far_ff  <= 1'b0;
         hdr_acc_ff  <= 1'b0;
      end else if (step) begin
         start_ff[0] <= start_in[0];
         start_ff[1] <= start_in[1];
         count_ff[0] <= count_in[0];
         count_ff[1] <= count_in[1];
         hdr_time_ff <= hdr_time_in;
         hdr_far_ff  <= hdr_far_in;
         hdr_acc_ff  <= hdr_acc_in;
      end
   end

endmodule

// File: design/radar_detection_gate_and_scan_counter_core.sv
// Radar detection gate and scan counter: input register, gate and scan logic, result register.
//
// Usage:
//   req_* carries one item per beat: op selects packet header, detection or end mark.
//   rsp_* returns exactly one result beat per request beat, in order.
//   csr_* writes the scan mode and the six detection thresholds; write only while idle.
// Path: an accepted request is held in the input register and, once the result register is
//   free, goes through one pass of compare and counter logic into the result register.
// Throughput: one beat per cycle while the result side does not stall; the single pass through
//   the gate and the scan counter update sets the rate.
// Stall: when rsp_stall holds a result, the input register can still take one more beat;
//   req_stall rises only when both the input and the result registers are full.
// Reset: synchronous, clears both valid flags, the scan counters and start times, the
//   current header, and loads the default scan mode (near) and thresholds.
module radar_detection_gate_and_scan_counter_core
   import rdg_pkg::*;
#(
   parameter int NEAR_PACKETS = NEAR_PACKETS_DEF,
   parameter int FAR_PACKETS  = FAR_PACKETS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ID_W-1:0]          req_packet_id,
   input  logic [DATA_W-1:0]        req_packet_time,
   input  logic signed [DATA_W-1:0] req_snr,
   input  logic signed [DATA_W-1:0] req_azimuth,
   input  logic signed [DATA_W-1:0] req_range_value,
   input  logic signed [DATA_W-1:0] req_radial_velocity,
   input  logic signed [DATA_W-1:0] req_elevation,
   input  logic signed [DATA_W-1:0] req_cross_section,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_keep_detection,
   output logic [1:0]               rsp_packet_status,
   output logic                     rsp_scan_complete,
   output logic [DATA_W-1:0]        rsp_scan_time
);

   // Configuration registers
   logic       mode_sel_ff;
   sample_type thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_sel_ff            <= MODE_NEAR;
         thr_ff.snr             <= THR_ZERO;
         thr_ff.azimuth         <= THR_MOST_NEG;
         thr_ff.range_value     <= THR_ZERO;
         thr_ff.radial_velocity <= THR_MOST_NEG;
         thr_ff.elevation       <= THR_MOST_NEG;
         thr_ff.cross_section   <= THR_MOST_NEG;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE_SEL:       mode_sel_ff            <= csr_data[0];
            CSR_SNR_MIN:        thr_ff.snr             <= csr_data;
            CSR_AZIMUTH_MIN:    thr_ff.azimuth         <= csr_data;
            CSR_RANGE_MIN:      thr_ff.range_value     <= csr_data;
            CSR_RADIAL_VEL_MIN: thr_ff.radial_velocity <= csr_data;
            CSR_ELEVATION_MIN:  thr_ff.elevation       <= csr_data;
            CSR_CROSS_SEC_MIN:  thr_ff.cross_section   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Handshake
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic advance;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   packet_id_ff;
   logic [DATA_W-1:0] packet_time_ff;
   sample_type        sample_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                     <= req_op;
         packet_id_ff              <= req_packet_id;
         packet_time_ff            <= req_packet_time;
         sample_ff.snr             <= req_snr;
         sample_ff.azimuth         <= req_azimuth;
         sample_ff.range_value     <= req_range_value;
         sample_ff.radial_velocity <= req_radial_velocity;
         sample_ff.elevation       <= req_elevation;
         sample_ff.cross_section   <= req_cross_section;
      end
   end

   // Gate and scan logic
   logic    det_pass;
   rsp_type result;

   rdg_gate u_gate (
      .sample (sample_ff),
      .thr    (thr_ff),
      .pass   (det_pass)
   );

   rdg_scan #(
      .NEAR_PACKETS (NEAR_PACKETS),
      .FAR_PACKETS  (FAR_PACKETS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .op          (op_ff),
      .packet_id   (packet_id_ff),
      .packet_time (packet_time_ff),
      .mode_sel    (mode_sel_ff),
      .det_pass    (det_pass),
      .result      (result)
   );

   // Result register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep_detection = rsp_ff.keep_detection;
   assign rsp_packet_status  = rsp_ff.packet_status;
   assign rsp_scan_complete  = rsp_ff.scan_complete;
   assign rsp_scan_time      = rsp_ff.scan_time;

endmodule

// File: design/rdg_checker.sv
// Port-level checks for the radar detection gate and scan counter, bound to the top level.
module rdg_checker
   import rdg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_keep_detection,
   input logic [1:0]        rsp_packet_status,
   input logic              rsp_scan_complete,
   input logic [DATA_W-1:0] rsp_scan_time
);

   // a kept detection carries no packet status
   a_keep_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep_detection |->
         rsp_packet_status == ST_NONE && !rsp_scan_complete)
      else $error("kept detection beat carries packet status");

   // completion only happens on an appended packet
   a_complete_append: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_complete |-> rsp_packet_status == ST_APPEND)
      else $error("scan complete without append status");

   // no scan time unless the packet joined a scan
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_packet_status == ST_NONE || rsp_packet_status == ST_IGNORED)
         |-> rsp_scan_time == '0)
      else $error("scan time on a beat that joined no scan");

   // input backs up only while a result is held by the receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while result side is free");

endmodule

bind radar_detection_gate_and_scan_counter_core rdg_checker u_rdg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_keep_detection (rsp_keep_detection),
   .rsp_packet_status  (rsp_packet_status),
   .rsp_scan_complete  (rsp_scan_complete),
   .rsp_scan_time      (rsp_scan_time)
);

// File: test/tb_radar_detection_gate_and_scan_counter_core.sv
// Self-checking testbench for the radar detection gate and scan counter core.
`timescale 1ns / 1ps

module tb_radar_detection_gate_and_scan_counter_core;
   import rdg_pkg::*;

   localparam logic [OP_W-1:0]          OP_SPARE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0]     CSR_SPARE = 3'd7;
   localparam logic signed [DATA_W-1:0] FIX_MAX   = 32'sh7FFF_FFFF;

   // one request beat as the core sees it
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] ptime;
      sample_type        s;
   } radar_item_type;

   // directed row: beat plus an optional hand-written expectation
   typedef struct packed {
      radar_item_type item;
      logic           typed;
      rsp_type        want;
   } script_row_type;

   localparam sample_type S_ZERO = '0;
   localparam sample_type S_MAX  = {6{FIX_MAX}};
   localparam sample_type S_MIN  = {6{THR_MOST_NEG}};
   // exactly at the reset thresholds
   localparam sample_type S_EDGE = {THR_ZERO, THR_MOST_NEG, THR_ZERO, {3{THR_MOST_NEG}}};
   // range one below its reset threshold
   localparam sample_type S_RANGE_LOW =
      {THR_ZERO, THR_MOST_NEG, 32'hFFFF_FFFF, {3{THR_MOST_NEG}}};

   localparam rsp_type R_ZERO = '0;
   localparam rsp_type R_IGN  = '{1'b0, ST_IGNORED, 1'b0, 32'h0};
   localparam rsp_type R_KEEP = '{1'b1, ST_NONE, 1'b0, 32'h0};

   localparam int SCRIPT_LEN = 25;

   script_row_type script [SCRIPT_LEN] = '{
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b1, R_IGN},
      '{'{OP_SPARE,  8'hFF, 32'hFFFF_FFFF, S_MAX},       1'b1, R_ZERO},
      '{'{OP_DETECT, 8'h03, 32'h0,         S_MAX},       1'b1, R_ZERO},
      '{'{OP_HEADER, 8'h03, 32'd100,       S_ZERO},      1'b1, R_ZERO},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_MAX},       1'b1, R_KEEP},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_MIN},       1'b1, R_ZERO},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_EDGE},      1'b0, R_ZERO},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_RANGE_LOW}, 1'b0, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b1,
        '{1'b0, ST_APPEND, 1'b0, 32'd100}},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b1, R_IGN},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_MAX},       1'b1, R_ZERO},
      '{'{OP_HEADER, 8'h01, 32'd100,       S_ZERO},      1'b1, R_ZERO},
      '{'{OP_DETECT, 8'h00, 32'h0,         S_MAX},       1'b1, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b1, R_IGN},
      '{'{OP_HEADER, 8'hFF, 32'd100,       S_MAX},       1'b0, R_ZERO},
      '{'{OP_HEADER, 8'h00, 32'd100,       S_MAX},       1'b0, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b1, R_IGN},
      '{'{OP_HEADER, 8'h05, 32'd200,       S_ZERO},      1'b0, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b0, R_ZERO},
      '{'{OP_HEADER, 8'h04, 32'h0,         S_ZERO},      1'b0, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b0, R_ZERO},
      '{'{OP_HEADER, 8'h03, 32'h0,         S_ZERO},      1'b0, R_ZERO},
      '{'{OP_END,    8'h00, 32'h0,         S_ZERO},      1'b0, R_ZERO},
      '{'{OP_HEADER, 8'h03, 32'hFFFF_FFFF, S_ZERO},      1'b0, R_ZERO},
      '{'{OP_END,    8'hFF, 32'hFFFF_FFFF, S_MAX},       1'b0, R_ZERO}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op = '0;
   logic [ID_W-1:0]          req_packet_id = '0;
   logic [DATA_W-1:0]        req_packet_time = '0;
   logic signed [DATA_W-1:0] req_snr = '0;
   logic signed [DATA_W-1:0] req_azimuth = '0;
   logic signed [DATA_W-1:0] req_range_value = '0;
   logic signed [DATA_W-1:0] req_radial_velocity = '0;
   logic signed [DATA_W-1:0] req_elevation = '0;
   logic signed [DATA_W-1:0] req_cross_section = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_keep_detection;
   logic [1:0]               rsp_packet_status;
   logic                     rsp_scan_complete;
   logic [DATA_W-1:0]        rsp_scan_time;

   // typed expectation that travels with the current beat
   logic    script_check = 1'b0;
   rsp_type script_want = '0;
   logic    no_idle = 1'b0;
   int      items_sent = 0;
   int      mismatch_count = 0;

   // predictor copy of configuration and scan state
   logic              pred_mode_far;
   sample_type        pred_min;
   logic [DATA_W-1:0] scan_start [2];
   logic [CNT_W-1:0]  scan_count [2];
   logic [DATA_W-1:0] hdr_time;
   logic              hdr_far;
   logic              hdr_open;
   rsp_type           gate_results_due [$];

   radar_detection_gate_and_scan_counter_core uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_packet_id       (req_packet_id),
      .req_packet_time     (req_packet_time),
      .req_snr             (req_snr),
      .req_azimuth         (req_azimuth),
      .req_range_value     (req_range_value),
      .req_radial_velocity (req_radial_velocity),
      .req_elevation       (req_elevation),
      .req_cross_section   (req_cross_section),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_keep_detection  (rsp_keep_detection),
      .rsp_packet_status   (rsp_packet_status),
      .rsp_scan_complete   (rsp_scan_complete),
      .rsp_scan_time       (rsp_scan_time)
   );

   always #2 clock = ~clock;

   // gate a beat and advance the scan counters; returns the result beat
   function automatic rsp_type gate_and_count(input radar_item_type it);
      rsp_type          r;
      logic             near_id;
      logic             far_id;
      int               t;
      logic [CNT_W-1:0] cap;
      r = '0;
      case (it.op)
         OP_HEADER: begin
            near_id  = it.id >= NEAR_ID_LO && it.id <= NEAR_ID_HI;
            far_id   = it.id >= FAR_ID_LO && it.id <= FAR_ID_HI;
            hdr_time = it.ptime;
            hdr_far  = far_id;
            hdr_open = (near_id && pred_mode_far == MODE_NEAR) ||
                       (far_id && pred_mode_far == MODE_FAR);
         end
         OP_DETECT: begin
            r.keep_detection = hdr_open &&
               it.s.snr >= pred_min.snr && it.s.azimuth >= pred_min.azimuth &&
               it.s.range_value >= pred_min.range_value &&
               it.s.radial_velocity >= pred_min.radial_velocity &&
               it.s.elevation >= pred_min.elevation &&
               it.s.cross_section >= pred_min.cross_section;
         end
         OP_END: begin
            if (!hdr_open) begin
               r.packet_status = ST_IGNORED;
            end else begin
               t   = hdr_far ? 1 : 0;
               cap = hdr_far ? CNT_W'(FAR_PACKETS_DEF) : CNT_W'(NEAR_PACKETS_DEF);
               // an unset start time takes this packet's time
               if (scan_start[t] == '0) scan_start[t] = hdr_time;
               if (scan_count[t] != cap && hdr_time == scan_start[t]) begin
                  r.packet_status = ST_APPEND;
                  r.scan_time     = scan_start[t];
                  scan_count[t]   = scan_count[t] + 1'b1;
                  if (scan_count[t] == cap) begin
                     r.scan_complete = 1'b1;
                     scan_count[t]   = '0;
                     scan_start[t]   = '0;
                  end
               end else begin
                  // restart drops the partial scan
                  r.packet_status = ST_RESTART;
                  r.scan_time     = hdr_time;
                  scan_count[t]   = CNT_W'(1);
                  scan_start[t]   = hdr_time;
               end
               hdr_open = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic log_miss(input string note, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: want k=%0b st=%0d c=%0b t=%h, got k=%0b st=%0d c=%0b t=%h",
                  note, want.keep_detection, want.packet_status, want.scan_complete,
                  want.scan_time, got.keep_detection, got.packet_status,
                  got.scan_complete, got.scan_time);
   endtask

   // monitor: config mirror, prediction on accepted requests, result compare
   always @(posedge clock) begin
      radar_item_type seen;
      rsp_type        want;
      rsp_type        got;
      if (reset) begin
         pred_mode_far = MODE_NEAR;
         pred_min = {THR_ZERO, THR_MOST_NEG, THR_ZERO, {3{THR_MOST_NEG}}};
         scan_start = '{default: '0};
         scan_count = '{default: '0};
         hdr_time = '0;
         hdr_far  = 1'b0;
         hdr_open = 1'b0;
         gate_results_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE_SEL:       pred_mode_far = csr_data[0];
               CSR_SNR_MIN:        pred_min.snr = csr_data;
               CSR_AZIMUTH_MIN:    pred_min.azimuth = csr_data;
               CSR_RANGE_MIN:      pred_min.range_value = csr_data;
               CSR_RADIAL_VEL_MIN: pred_min.radial_velocity = csr_data;
               CSR_ELEVATION_MIN:  pred_min.elevation = csr_data;
               CSR_CROSS_SEC_MIN:  pred_min.cross_section = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen.op    = req_op;
            seen.id    = req_packet_id;
            seen.ptime = req_packet_time;
            seen.s     = {req_snr, req_azimuth, req_range_value, req_radial_velocity,
                          req_elevation, req_cross_section};
            want = gate_and_count(seen);
            if (script_check) want = script_want;
            gate_results_due = {gate_results_due, want};
         end
         if (rsp_valid && !rsp_stall) begin
            got.keep_detection = rsp_keep_detection;
            got.packet_status  = status_type'(rsp_packet_status);
            got.scan_complete  = rsp_scan_complete;
            got.scan_time      = rsp_scan_time;
            if (gate_results_due.size() == 0) begin
               log_miss("unexpected result beat", R_ZERO, got);
            end else begin
               want = gate_results_due.pop_front();
               if (got.keep_detection !== want.keep_detection ||
                   got.packet_status !== want.packet_status ||
                   got.scan_complete !== want.scan_complete ||
                   got.scan_time !== want.scan_time)
                  log_miss("result mismatch", want, got);
            end
         end
      end
   end

   // result side backpressure
   always @(posedge clock) rsp_stall <= !no_idle && ($urandom_range(99) < 8);

   function automatic radar_item_type noise_item(input logic [OP_W-1:0] op);
      radar_item_type it;
      it.op    = op;
      it.id    = ID_W'($urandom);
      it.ptime = $urandom;
      it.s     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return it;
   endfunction

   // detection values clustered around the thresholds
   function automatic sample_type make_sample(input sample_type mins);
      logic signed [DATA_W-1:0] lo [6];
      logic signed [DATA_W-1:0] v [6];
      logic                     all_pass;
      int                       i;
      lo[0] = mins.snr;
      lo[1] = mins.azimuth;
      lo[2] = mins.range_value;
      lo[3] = mins.radial_velocity;
      lo[4] = mins.elevation;
      lo[5] = mins.cross_section;
      all_pass = $urandom_range(99) < 60;
      for (i = 0; i < 6; i++) begin
         case (all_pass ? $urandom_range(2, 4) : $urandom_range(0, 5))
            0: v[i] = $urandom;
            1: v[i] = lo[i] - 1;
            2: v[i] = lo[i];
            3: begin
               v[i] = lo[i] + $urandom_range(0, 1000);
               if (v[i] < lo[i]) v[i] = FIX_MAX;
            end
            4: v[i] = FIX_MAX;
            default: v[i] = THR_MOST_NEG;
         endcase
      end
      return {v[0], v[1], v[2], v[3], v[4], v[5]};
   endfunction

   // drive one request beat and wait until it is taken
   task automatic send_item(input radar_item_type it, input logic typed, input rsp_type want);
      if (!no_idle && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= it.op;
      req_packet_id       <= it.id;
      req_packet_time     <= it.ptime;
      req_snr             <= it.s.snr;
      req_azimuth         <= it.s.azimuth;
      req_range_value     <= it.s.range_value;
      req_radial_velocity <= it.s.radial_velocity;
      req_elevation       <= it.s.elevation;
      req_cross_section   <= it.s.cross_section;
      script_check        <= typed;
      script_want         <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // let every pending result come back, plus the pipeline depth
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (gate_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input logic far, input sample_type mins, input logic spare);
      logic [DATA_W-1:0] word;
      word    = $urandom;
      word[0] = far;
      csr_beat(CSR_MODE_SEL, word);
      csr_beat(CSR_SNR_MIN, mins.snr);
      csr_beat(CSR_AZIMUTH_MIN, mins.azimuth);
      csr_beat(CSR_RANGE_MIN, mins.range_value);
      csr_beat(CSR_RADIAL_VEL_MIN, mins.radial_velocity);
      csr_beat(CSR_ELEVATION_MIN, mins.elevation);
      csr_beat(CSR_CROSS_SEC_MIN, mins.cross_section);
      if (spare) csr_beat(CSR_SPARE, $urandom);
      csr_write_en <= 1'b0;
   endtask

   // mostly well-formed packets that fill scans, with some noise mixed in
   task automatic run_random(input int n_items, input logic far, input sample_type mins);
      int                stop_at;
      int                cap;
      int                run_left;
      int                kind;
      logic [DATA_W-1:0] run_time;
      radar_item_type    it;
      stop_at  = items_sent + n_items;
      cap      = far ? FAR_PACKETS_DEF : NEAR_PACKETS_DEF;
      run_left = 0;
      run_time = '0;
      while (items_sent < stop_at) begin
         // new scan run: mostly full length, sometimes cut short to force a restart
         if (run_left == 0) begin
            run_time = ($urandom_range(9) == 0) ? '0 : $urandom;
            run_left = ($urandom_range(9) < 7) ? cap : $urandom_range(1, cap - 1);
         end
         kind = $urandom_range(99);
         it = noise_item(OP_HEADER);
         if (kind < 80) begin
            it.id = far ? ID_W'($urandom_range(FAR_ID_LO, FAR_ID_HI))
                        : ID_W'($urandom_range(NEAR_ID_LO, NEAR_ID_HI));
            it.ptime = run_time;
            run_left--;
         end else if (kind < 87) begin
            it.id = far ? ID_W'($urandom_range(NEAR_ID_LO, NEAR_ID_HI))
                        : ID_W'($urandom_range(FAR_ID_LO, FAR_ID_HI));
         end else if (kind < 91) begin
            do it.id = ID_W'($urandom); while (it.id >= FAR_ID_LO && it.id <= NEAR_ID_HI);
         end
         if (kind < 91) begin
            send_item(it, 1'b0, R_ZERO);
            repeat ($urandom_range(0, 3)) begin
               it   = noise_item(OP_DETECT);
               it.s = make_sample(mins);
               send_item(it, 1'b0, R_ZERO);
            end
            send_item(noise_item(OP_END), 1'b0, R_ZERO);
         end else if (kind < 95) begin
            // stray detection and end mark with no header of their own
            it   = noise_item(OP_DETECT);
            it.s = make_sample(mins);
            send_item(it, 1'b0, R_ZERO);
            send_item(noise_item(OP_END), 1'b0, R_ZERO);
         end else if (kind < 98) begin
            send_item(noise_item(OP_SPARE), 1'b0, R_ZERO);
         end else begin
            // header left open until a later header replaces it or an end mark closes it
            it.id = far ? ID_W'($urandom_range(FAR_ID_LO, FAR_ID_HI))
                        : ID_W'($urandom_range(NEAR_ID_LO, NEAR_ID_HI));
            send_item(it, 1'b0, R_ZERO);
         end
      end
   endtask

   // main sequence
   initial begin
      sample_type mins;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows on reset configuration
      foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);
      wait_idle();

      // near scans, random thresholds
      mins = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      load_config(MODE_NEAR, mins, 1'b0);
      run_random(175, MODE_NEAR, mins);
      wait_idle();

      // far scans, everything passes, no idling on either side
      no_idle <= 1'b1;
      load_config(MODE_FAR, S_MIN, 1'b0);
      run_random(175, MODE_FAR, S_MIN);
      wait_idle();
      no_idle <= 1'b0;

      // far scans, only the largest values pass
      load_config(MODE_FAR, S_MAX, 1'b0);
      run_random(175, MODE_FAR, S_MAX);
      wait_idle();

      // back to near with fresh thresholds and a write to the unused index
      mins = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      load_config(MODE_NEAR, mins, 1'b1);
      run_random(175, MODE_NEAR, mins);
      wait_idle();

      if (mismatch_count == 0 && gate_results_due.size() == 0)
         $display("** radar_detection_gate_and_scan_counter_core: PASSED **");
      else
         $display("** radar_detection_gate_and_scan_counter_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("** radar_detection_gate_and_scan_counter_core: FAILED **");
      $finish;
   end

endmodule
